>>> rtl/core/park_rot_pkg.sv
// shared constants for the park rotation datapath
package park_rot_pkg;

  // working width of the turn fraction
  localparam int TURN_WIDTH = 32;

  // cordic iteration count and fraction bits carried in the vector
  localparam int CORDIC_STAGES = 24;
  localparam int GUARD_BITS    = 8;

  // reciprocal of the cordic gain in q22
  localparam int        KINV_SHIFT = 22;
  localparam int        KINV_WIDTH = KINV_SHIFT + 1;
  localparam logic [KINV_WIDTH-1:0] KINV_Q22 = KINV_WIDTH'(2547003);

  // rotation direction codes
  localparam logic KIND_FORWARD = 1'b0;
  localparam logic KIND_INVERSE = 1'b1;

  // quarter-turn codes taken from the top two angle bits
  localparam logic [1:0] QUAD_0   = 2'd0;
  localparam logic [1:0] QUAD_90  = 2'd1;
  localparam logic [1:0] QUAD_180 = 2'd2;
  localparam logic [1:0] QUAD_270 = 2'd3;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [TURN_WIDTH-1:0] ATAN_TURN32 [CORDIC_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

endpackage

>>> rtl/core/park_rotation.sv
// park and inverse park rotation: pipelined cordic with gain correction
//
// Rotates a vector (vec_x, vec_y) by the rotor angle: forward park (kind 0)
// turns by minus the angle, inverse park (kind 1) by plus the angle. One
// vector is taken per clock while the pipeline is not held; it passes one
// stage for the quarter-turn pre-rotation, one per cordic iteration (24),
// one for the gain-correction multiply and one for rounding into the output
// register. All stages share one enable: while a result sits in the output
// register and out_ready is low, the whole pipeline holds and in_ready is
// low; otherwise a transfer can happen in every cycle. Results are
// DATA_WIDTH+1 bits and never saturate.
module park_rotation #(
  parameter int DATA_WIDTH  = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  logic [DATA_WIDTH-1:0] vec_x,
  input  logic [DATA_WIDTH-1:0] vec_y,
  input  logic [ANGLE_WIDTH-1:0] rotor_angle,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH:0]   rot_x,
  output logic [DATA_WIDTH:0]   rot_y
);
  import park_rot_pkg::*;

  // vector width: guard bits plus headroom for the cordic gain and sqrt(2)
  localparam int VW    = DATA_WIDTH + GUARD_BITS + 3;
  localparam int PW    = VW + KINV_WIDTH;
  localparam int RSH   = KINV_SHIFT + GUARD_BITS;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (RSH - 1);

  logic advance;

  // pipeline registers
  logic                   v_pipe [0:CORDIC_STAGES];
  logic signed [VW-1:0]   x_pipe [0:CORDIC_STAGES];
  logic signed [VW-1:0]   y_pipe [0:CORDIC_STAGES];
  logic signed [TURN_WIDTH-1:0] z_pipe [0:CORDIC_STAGES-1];

  logic                   v_mul;
  logic signed [PW-1:0]   prod_x;
  logic signed [PW-1:0]   prod_y;

  // one enable for the whole pipe: hold only when the output is blocked
  assign advance  = !(out_valid && !out_ready);
  assign in_ready = advance;

  // angle widening, direction and quarter-turn split
  logic [TURN_WIDTH-1:0]  a_wide;
  logic [TURN_WIDTH-1:0]  a_dir;
  logic [1:0]             quad;
  logic signed [VW-1:0]   x_ext;
  logic signed [VW-1:0]   y_ext;
  logic signed [VW-1:0]   x_pre;
  logic signed [VW-1:0]   y_pre;

  always_comb begin
    a_wide = TURN_WIDTH'(rotor_angle) << (TURN_WIDTH - ANGLE_WIDTH);
    a_dir  = (kind == KIND_INVERSE) ? a_wide : (TURN_WIDTH'(0) - a_wide);
    quad   = a_dir[TURN_WIDTH-1 -: 2];
    x_ext  = {{(VW-DATA_WIDTH){vec_x[DATA_WIDTH-1]}}, vec_x} <<< GUARD_BITS;
    y_ext  = {{(VW-DATA_WIDTH){vec_y[DATA_WIDTH-1]}}, vec_y} <<< GUARD_BITS;
    unique case (quad)
      QUAD_90: begin
        x_pre = -y_ext;
        y_pre = x_ext;
      end
      QUAD_180: begin
        x_pre = -x_ext;
        y_pre = -y_ext;
      end
      QUAD_270: begin
        x_pre = y_ext;
        y_pre = -x_ext;
      end
      default: begin
        x_pre = x_ext;
        y_pre = y_ext;
      end
    endcase
  end

  // pre-rotation stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v_pipe[0] <= 1'b0;
    end else if (advance) begin
      v_pipe[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x_pipe[0] <= x_pre;
      y_pipe[0] <= y_pre;
      z_pipe[0] <= {2'b00, a_dir[TURN_WIDTH-3:0]};
    end
  end

  // cordic iterations, one register stage each
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic signed [VW-1:0] xs;
    logic signed [VW-1:0] ys;
    logic                 pos;

    assign xs  = x_pipe[i] >>> i;
    assign ys  = y_pipe[i] >>> i;
    assign pos = !z_pipe[i][TURN_WIDTH-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v_pipe[i+1] <= 1'b0;
      end else if (advance) begin
        v_pipe[i+1] <= v_pipe[i];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        x_pipe[i+1] <= pos ? (x_pipe[i] - ys) : (x_pipe[i] + ys);
        y_pipe[i+1] <= pos ? (y_pipe[i] + xs) : (y_pipe[i] - xs);
      end
    end

    // residual angle, not needed after the last iteration
    if (i < CORDIC_STAGES - 1) begin : g_angle
      always_ff @(posedge clk) begin
        if (advance) begin
          z_pipe[i+1] <= pos ? (z_pipe[i] - $signed(ATAN_TURN32[i]))
                             : (z_pipe[i] + $signed(ATAN_TURN32[i]));
        end
      end
    end
  end

  // gain correction multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul <= 1'b0;
    end else if (advance) begin
      v_mul <= v_pipe[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_x <= PW'(x_pipe[CORDIC_STAGES]) * $signed({1'b0, KINV_Q22});
      prod_y <= PW'(y_pipe[CORDIC_STAGES]) * $signed({1'b0, KINV_Q22});
    end
  end

  // round half up and drop the fraction into the output register
  logic signed [PW-1:0] rnd_x;
  logic signed [PW-1:0] rnd_y;

  assign rnd_x = (prod_x + HALF) >>> RSH;
  assign rnd_y = (prod_y + HALF) >>> RSH;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v_mul;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rot_x <= rnd_x[DATA_WIDTH:0];
      rot_y <= rnd_y[DATA_WIDTH:0];
    end
  end

`ifndef ASSERT_OFF
  // a blocked output must stop new transfers at the input
  a_block_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while output blocked");

  // an accepted vector enters the first stage
  a_enter_pipe: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v_pipe[0])
    else $error("accepted vector lost at pipeline entry");

  // a stall freezes the last cordic stage and the multiplier stage
  a_hold_pipe: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(v_mul) && $stable(v_pipe[CORDIC_STAGES])))
    else $error("pipeline moved during stall");

  // the multiplier stage feeds the output register when the pipe moves
  a_mul_to_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_valid == $past(v_mul)))
    else $error("valid bit dropped between multiplier and output");
`endif

endmodule
